[hdl/particle_integration_step_assert.svh]
// Assertion macros shared by the particle step RTL.
`ifndef PARTICLE_INTEGRATION_STEP_ASSERT_SVH
`define PARTICLE_INTEGRATION_STEP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIS_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("particle step check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PIS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("particle step check failed");

`endif

[hdl/pis_pkg.sv]
package pis_pkg;

    // Pipeline depth: one register stage per entry of the valid chain
    localparam int NUM_STAGES = 8;
    localparam int NUM_LANES  = 3;
    localparam int LANE_Y     = 1;

    // Q16.16 fraction width (the shift applied after each multiply)
    localparam int FRAC_BITS = 16;

    // Floor bounce factors in Q16.16
    localparam logic signed [16:0] FIX_NEG_POINT3 = -17'sd19661;
    localparam logic signed [16:0] FIX_POINT7     = 17'sd45875;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    // Widest product in the datapath (32 x 19)
    localparam int PROD_W = 51;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
    } rec_t;

    // Per-item context that rides along the pipeline
    typedef struct packed {
        rec_t               rec;
        logic signed [31:0] nl;
        logic               alive;
        logic        [17:0] dt;
        logic        [16:0] drag;
    } ctx_t;

    // Shift right by 16 rounding half up, then clamp to signed 32 bits
    function automatic logic signed [31:0] round_sat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0] u;
        logic signed [35:0]     q;
        u = (PROD_W + 1)'(p) + (PROD_W + 1)'(33'sd32768);
        q = 36'(u >>> FRAC_BITS);
        if (q > 36'(SAT_MAX)) begin
            return SAT_MAX;
        end
        else if (q < 36'(SAT_MIN)) begin
            return SAT_MIN;
        end
        else begin
            return q[31:0];
        end
    endfunction

    // Saturating signed 32 bit add
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s > 33'(SAT_MAX)) begin
            return SAT_MAX;
        end
        else if (s < 33'(SAT_MIN)) begin
            return SAT_MIN;
        end
        else begin
            return s[31:0];
        end
    endfunction

endpackage

[hdl/pis_mul.sv]
// Registered signed multiplier, full-width product.
module pis_mul #(
    parameter int AW = 32,
    parameter int BW = 19
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [AW-1:0]       a,
    input  logic signed [BW-1:0]       b,
    output logic signed [AW+BW-1:0]    p
);

    logic signed [AW+BW-1:0] p_reg;
    logic signed [AW+BW-1:0] p_next;

    assign p_next = (AW + BW)'(a) * (AW + BW)'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

[hdl/particle_integration_step.sv]
// Particle integration step: one particle record in, one updated record out.
// Input channel: item_valid / item_stall with the record fields, grav_accel,
// drag_factor and step_time. Output channel: result_valid / result_stall with
// the new_* fields, new_life and still_alive.
// Throughput: one item per cycle unless stalled; the datapath is an 8-stage
// pipeline with registered multipliers (a gravity product, and drag, position
// and floor bounce products in three lanes each), each product rounded and
// saturated in the stage after its multiply.
// Stall: when a result is valid and result_stall is high, the whole pipeline
// holds and item_stall goes high; bubbles hold in place along with the items,
// so no item is accepted for as long as a stall lasts.
// Reset: rst_n clears all stage valid bits; data registers are not reset.
// Dead particles (life_left - step_time <= 0) return position and velocity
// unchanged with still_alive low.
`include "particle_integration_step_assert.svh"

module particle_integration_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic        [30:0] life_left,
    input  logic signed [31:0] grav_accel,
    input  logic        [16:0] drag_factor,
    input  logic        [17:0] step_time,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] new_pos_x,
    output logic signed [31:0] new_pos_y,
    output logic signed [31:0] new_pos_z,
    output logic signed [31:0] new_vel_x,
    output logic signed [31:0] new_vel_y,
    output logic signed [31:0] new_vel_z,
    output logic signed [31:0] new_life,
    output logic               still_alive
);

    localparam int NS = pis_pkg::NUM_STAGES;
    localparam int NL = pis_pkg::NUM_LANES;

    logic                 en;
    logic [NS-1:0]        v_reg;
    pis_pkg::ctx_t        ctx_reg [NS-1];
    pis_pkg::ctx_t        ctx_next;

    // Global advance: hold everything only while a result waits
    assign en         = !(v_reg[NS-1] && result_stall);
    assign item_stall = !en;

    // Stage 1 context: life update and input capture
    always_comb
    begin
        ctx_next.rec.pos_x = pos_x;
        ctx_next.rec.pos_y = pos_y;
        ctx_next.rec.pos_z = pos_z;
        ctx_next.rec.vel_x = vel_x;
        ctx_next.rec.vel_y = vel_y;
        ctx_next.rec.vel_z = vel_z;
        ctx_next.nl        = {1'b0, life_left} - {14'd0, step_time};
        ctx_next.alive     = !ctx_next.nl[31] && (ctx_next.nl != 32'sd0);
        ctx_next.dt        = step_time;
        ctx_next.drag      = drag_factor;
    end

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NS-2:0], item_valid};
        end
    end

    // Context chain
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[0] <= ctx_next;
            for (int i = 1; i < NS - 1; i++)
            begin
                ctx_reg[i] <= ctx_reg[i-1];
            end
        end
    end

    // Stage 1: gravity * step
    logic signed [50:0] pg;

    pis_mul #(.AW(32), .BW(19)) u_mul_grav (
        .clk (clk),
        .en  (en),
        .a   (grav_accel),
        .b   ($signed({1'b0, step_time})),
        .p   (pg)
    );

    // Stage 2: vertical velocity picks up gravity
    logic signed [31:0] vy1_reg;
    logic signed [31:0] vy1_next;

    assign vy1_next = pis_pkg::sat_add(ctx_reg[0].rec.vel_y, pis_pkg::round_sat(pg));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vy1_reg <= vy1_next;
        end
    end

    // Stage 3: drag products
    logic signed [31:0] v3_in [NL];
    logic signed [49:0] pd    [NL];

    assign v3_in[0] = ctx_reg[1].rec.vel_x;
    assign v3_in[1] = vy1_reg;
    assign v3_in[2] = ctx_reg[1].rec.vel_z;

    // Stage 4: dragged velocity
    logic signed [31:0] vd4_reg [NL];
    logic signed [31:0] vd5_reg [NL];
    logic signed [31:0] vd6_reg [NL];
    logic signed [31:0] vd7_reg [NL];

    // Stage 5: velocity * step; stage 6: position sum
    logic signed [50:0] pp      [NL];
    logic signed [31:0] pos5    [NL];
    logic signed [31:0] np6_reg [NL];
    logic signed [31:0] np7_reg [NL];
    logic signed [31:0] np6_next [NL];
    logic               floor6_reg;
    logic               floor7_reg;

    // Stage 7: floor bounce products
    logic signed [48:0] pf     [NL];
    logic signed [16:0] bounce [NL];

    assign pos5[0] = ctx_reg[4].rec.pos_x;
    assign pos5[1] = ctx_reg[4].rec.pos_y;
    assign pos5[2] = ctx_reg[4].rec.pos_z;

    generate
        for (genvar g = 0; g < NL; g++)
        begin : g_lane
            assign bounce[g] = (g == pis_pkg::LANE_Y) ? pis_pkg::FIX_NEG_POINT3
                                                      : pis_pkg::FIX_POINT7;

            pis_mul #(.AW(32), .BW(18)) u_mul_drag (
                .clk (clk),
                .en  (en),
                .a   (v3_in[g]),
                .b   ($signed({1'b0, ctx_reg[1].drag})),
                .p   (pd[g])
            );

            pis_mul #(.AW(32), .BW(19)) u_mul_step (
                .clk (clk),
                .en  (en),
                .a   (vd4_reg[g]),
                .b   ($signed({1'b0, ctx_reg[3].dt})),
                .p   (pp[g])
            );

            pis_mul #(.AW(32), .BW(17)) u_mul_bounce (
                .clk (clk),
                .en  (en),
                .a   (vd6_reg[g]),
                .b   (bounce[g]),
                .p   (pf[g])
            );

            assign np6_next[g] = pis_pkg::sat_add(pos5[g], pis_pkg::round_sat(pp[g]));
        end
    endgenerate

    // Lane registers for stages 4 through 7
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NL; i++)
            begin
                vd4_reg[i] <= pis_pkg::round_sat(51'(pd[i]));
                vd5_reg[i] <= vd4_reg[i];
                vd6_reg[i] <= vd5_reg[i];
                vd7_reg[i] <= vd6_reg[i];
                np6_reg[i] <= np6_next[i];
                np7_reg[i] <= np6_reg[i];
            end
            floor6_reg <= np6_next[pis_pkg::LANE_Y][31];
            floor7_reg <= floor6_reg;
        end
    end

    // Stage 8: select dead / bounce / free-flight result
    pis_pkg::rec_t      out_reg;
    pis_pkg::rec_t      out_next;
    logic signed [31:0] life_reg;
    logic               alive_reg;

    always_comb
    begin
        if (!ctx_reg[NS-2].alive)
        begin
            out_next = ctx_reg[NS-2].rec;
        end
        else if (floor7_reg)
        begin
            out_next.pos_x = np7_reg[0];
            out_next.pos_y = 32'sd0;
            out_next.pos_z = np7_reg[2];
            out_next.vel_x = pis_pkg::round_sat(51'(pf[0]));
            out_next.vel_y = pis_pkg::round_sat(51'(pf[1]));
            out_next.vel_z = pis_pkg::round_sat(51'(pf[2]));
        end
        else
        begin
            out_next.pos_x = np7_reg[0];
            out_next.pos_y = np7_reg[1];
            out_next.pos_z = np7_reg[2];
            out_next.vel_x = vd7_reg[0];
            out_next.vel_y = vd7_reg[1];
            out_next.vel_z = vd7_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg   <= out_next;
            life_reg  <= ctx_reg[NS-2].nl;
            alive_reg <= ctx_reg[NS-2].alive;
        end
    end

    assign result_valid = v_reg[NS-1];
    assign new_pos_x    = out_reg.pos_x;
    assign new_pos_y    = out_reg.pos_y;
    assign new_pos_z    = out_reg.pos_z;
    assign new_vel_x    = out_reg.vel_x;
    assign new_vel_y    = out_reg.vel_y;
    assign new_vel_z    = out_reg.vel_z;
    assign new_life     = life_reg;
    assign still_alive  = alive_reg;

    // Checks
    `PIS_ASSERT_NOW(a_alive_above_floor, clk, rst_n,
        result_valid && still_alive, !new_pos_y[31])
    `PIS_ASSERT_NOW(a_alive_life_pos, clk, rst_n,
        result_valid && still_alive, !new_life[31] && (new_life != 32'sd0))
    `PIS_ASSERT_NOW(a_dead_life_nonpos, clk, rst_n,
        result_valid && !still_alive, new_life[31] || (new_life == 32'sd0))
    `PIS_ASSERT_NEXT(a_last_stage_moves, clk, rst_n,
        v_reg[NS-2] && en, result_valid)

endmodule

[verif/tb_particle_integration_step.sv]
module tb_particle_integration_step;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 1950;
    localparam int CALM_TAIL      = 300;
    localparam int PIPE_LATENCY   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    // Fields of one particle record plus the per-step parameters
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic        [30:0] life_left;
        logic signed [31:0] grav_accel;
        logic        [16:0] drag_factor;
        logic        [17:0] step_time;
    } particle_in_t;

    // Fields of one updated record
    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic [31:0] life;
        logic        alive;
    } particle_out_t;

    // Predicts each updated record and checks the block's results in order
    class particle_scoreboard;
        localparam longint BOUNCE_Y = -19661;
        localparam longint DAMP_XZ  = 45875;

        particle_out_t pending_q[$];
        int            errors;

        function new();
            errors = 0;
        endfunction

        task report(input string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function longint clamp32(input longint v);
            if (v > 64'sd2147483647)
            begin
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648)
            begin
                return -64'sd2147483648;
            end
            return v;
        endfunction

        // Q16.16 product: round half up, then clamp
        function longint mul_q16(input longint a, input longint b);
            return clamp32((a * b + 64'sd32768) >>> 16);
        endfunction

        function particle_out_t step_particle(input particle_in_t it);
            particle_out_t o;
            longint px, py, pz, vx, vy, vz, life, grav, drag, dt, nl;
            bit alive;
            px   = longint'(it.pos_x);
            py   = longint'(it.pos_y);
            pz   = longint'(it.pos_z);
            vx   = longint'(it.vel_x);
            vy   = longint'(it.vel_y);
            vz   = longint'(it.vel_z);
            life = longint'(it.life_left);
            grav = longint'(it.grav_accel);
            drag = longint'(it.drag_factor);
            dt   = longint'(it.step_time);
            nl    = life - dt;
            alive = (nl > 0);
            if (alive)
            begin
                // gravity, then drag, then position update
                vy = clamp32(vy + mul_q16(grav, dt));
                vx = mul_q16(vx, drag);
                vy = mul_q16(vy, drag);
                vz = mul_q16(vz, drag);
                px = clamp32(px + mul_q16(vx, dt));
                py = clamp32(py + mul_q16(vy, dt));
                pz = clamp32(pz + mul_q16(vz, dt));
                // floor bounce
                if (py < 0)
                begin
                    py = 0;
                    vy = mul_q16(vy, BOUNCE_Y);
                    vx = mul_q16(vx, DAMP_XZ);
                    vz = mul_q16(vz, DAMP_XZ);
                end
            end
            o.pos_x = px[31:0];
            o.pos_y = py[31:0];
            o.pos_z = pz[31:0];
            o.vel_x = vx[31:0];
            o.vel_y = vy[31:0];
            o.vel_z = vz[31:0];
            o.life  = nl[31:0];
            o.alive = alive;
            return o;
        endfunction

        function void note_item(input particle_in_t it);
            pending_q.push_back(step_particle(it));
        endfunction

        task compare_field(input string name, input logic [31:0] got,
                           input logic [31:0] want);
            if (got !== want)
            begin
                report($sformatf("%s got %h expected %h", name, got, want));
            end
        endtask

        task check_result(input particle_out_t got);
            particle_out_t want;
            if (pending_q.size() == 0)
            begin
                report("result with no item outstanding");
                return;
            end
            want = pending_q.pop_front();
            compare_field("new_pos_x", got.pos_x, want.pos_x);
            compare_field("new_pos_y", got.pos_y, want.pos_y);
            compare_field("new_pos_z", got.pos_z, want.pos_z);
            compare_field("new_vel_x", got.vel_x, want.vel_x);
            compare_field("new_vel_y", got.vel_y, want.vel_y);
            compare_field("new_vel_z", got.vel_z, want.vel_z);
            compare_field("new_life", got.life, want.life);
            compare_field("still_alive", {31'b0, got.alive}, {31'b0, want.alive});
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic        [30:0] life_left;
    logic signed [31:0] grav_accel;
    logic        [16:0] drag_factor;
    logic        [17:0] step_time;
    logic               result_valid;
    logic               result_stall;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic signed [31:0] new_life;
    logic               still_alive;

    logic               idle_en;

    particle_scoreboard sb = new();

    particle_integration_step uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .vel_z        (vel_z),
        .life_left    (life_left),
        .grav_accel   (grav_accel),
        .drag_factor  (drag_factor),
        .step_time    (step_time),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .new_pos_x    (new_pos_x),
        .new_pos_y    (new_pos_y),
        .new_pos_z    (new_pos_z),
        .new_vel_x    (new_vel_x),
        .new_vel_y    (new_vel_y),
        .new_vel_z    (new_vel_z),
        .new_life     (new_life),
        .still_alive  (still_alive)
    );

    always #2 clk = ~clk;

    function automatic particle_in_t make_item(
        input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
        input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] vz,
        input logic [30:0] life, input logic [31:0] grav,
        input logic [16:0] drag, input logic [17:0] dt);
        particle_in_t it;
        it.pos_x       = px;
        it.pos_y       = py;
        it.pos_z       = pz;
        it.vel_x       = vx;
        it.vel_y       = vy;
        it.vel_z       = vz;
        it.life_left   = life;
        it.grav_accel  = grav;
        it.drag_factor = drag;
        it.step_time   = dt;
        return it;
    endfunction

    // Mix of full-range, near-zero, mid-range and extreme values
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 2 ** 21) - 2 ** 20;
            2: return $urandom_range(0, 2 ** 27) - 2 ** 26;
            3:
            begin
                case ($urandom_range(0, 4))
                    0: return S_MAX;
                    1: return S_MIN;
                    2: return 32'h0;
                    3: return 32'hFFFF_FFFF;
                    default: return Q_ONE;
                endcase
            end
            default: return $urandom_range(0, 2 ** 18) - 2 ** 17;
        endcase
    endfunction

    function automatic particle_in_t random_item();
        particle_in_t it;
        int           r;
        logic [31:0]  w;
        r = $urandom_range(0, 9);
        it.pos_x = rand_word();
        it.pos_y = rand_word();
        it.pos_z = rand_word();
        it.vel_x = rand_word();
        it.vel_y = rand_word();
        it.vel_z = rand_word();
        // mostly earth-like gravity, sometimes anything
        if (r < 6)
        begin
            it.grav_accel = -32'sd642253 + $signed($urandom_range(0, 200000)) - 100000;
        end
        else
        begin
            it.grav_accel = rand_word();
        end
        w = $urandom;
        it.life_left   = (r < 2) ? 31'($urandom_range(0, 300000)) : w[30:0];
        it.drag_factor = (r < 7) ? 17'($urandom_range(52000, 65536))
                                 : 17'($urandom_range(0, 131071));
        it.step_time   = (r < 8) ? 18'($urandom_range(0, 131072))
                                 : 18'($urandom_range(0, 262143));
        return it;
    endfunction

    // Present one item, optionally after an idle burst, and wait for acceptance
    task automatic send_item(input particle_in_t it, input bit allow_gap);
        int gap;
        if (allow_gap && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            gap = $urandom_range(1, 18);
            repeat (gap) @(posedge clk);
        end
        pos_x       <= it.pos_x;
        pos_y       <= it.pos_y;
        pos_z       <= it.pos_z;
        vel_x       <= it.vel_x;
        vel_y       <= it.vel_y;
        vel_z       <= it.vel_z;
        life_left   <= it.life_left;
        grav_accel  <= it.grav_accel;
        drag_factor <= it.drag_factor;
        step_time   <= it.step_time;
        item_valid  <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (item_stall);
        sb.note_item(it);
    endtask

    // Result side stall bursts
    initial
    begin : stall_gen
        forever
        begin
            @(posedge clk);
            if (idle_en && $urandom_range(0, 7) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin : result_mon
        particle_out_t seen;
        if (rst_n && result_valid && !result_stall)
        begin
            seen = {new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                    new_vel_z, new_life, still_alive};
            sb.check_result(seen);
        end
    end

    // Ends the run if nothing moves on either channel for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : main_seq
        bit calm;
        bit gaps;
        clk          = 1'b0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        result_stall = 1'b0;
        idle_en      = 1'b1;
        pos_x        = '0;
        pos_y        = '0;
        pos_z        = '0;
        vel_x        = '0;
        vel_y        = '0;
        vel_z        = '0;
        life_left    = '0;
        grav_accel   = '0;
        drag_factor  = '0;
        step_time    = '0;
        calm         = 1'b0;
        gaps         = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // dead with zero life and zero step
        send_item(make_item(0, 0, 0, 0, 0, 0, 31'd0, 0, 17'd0, 18'd0), gaps);
        // longest life, no step: record passes unchanged while alive
        send_item(make_item(Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0, -Q_ONE,
                            31'h7FFF_FFFF, 0, 17'd65536, 18'd0), gaps);
        // dead, life far below step: extremes pass through, new life negative
        send_item(make_item(S_MAX, S_MIN, 32'd1, S_MIN, S_MAX, 32'hFFFF_FFFF,
                            31'd1, S_MIN, 17'h1FFFF, 18'h3FFFF), gaps);
        // life exactly used up
        send_item(make_item(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                            31'd65536, -32'sd642253, 17'd60000, 18'd65536), gaps);
        // alive by one LSB
        send_item(make_item(Q_ONE, 32'd10 << 16, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                            31'd65537, -32'sd642253, 17'd60000, 18'd65536), gaps);
        // drag above one and positive saturation everywhere
        send_item(make_item(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX,
                            31'h7FFF_FFFF, S_MAX, 17'h1FFFF, 18'h3FFFF), gaps);
        // negative saturation with a floor hit
        send_item(make_item(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN,
                            31'h7FFF_FFFF, S_MIN, 17'h1FFFF, 18'h3FFFF), gaps);
        // ordinary floor hit: falling particle crosses y = 0
        send_item(make_item(Q_ONE, 32'h0000_8000, -Q_ONE, 32'd3 << 16,
                            -(32'd10 << 16), -(32'd2 << 16),
                            31'd5 << 16, -32'sd642253, 17'd64000, 18'd32768), gaps);
        // rounding ties in the drag products
        send_item(make_item(Q_ONE, Q_ONE, Q_ONE, 32'd1, 32'd3, 32'hFFFF_FFFF,
                            31'd100, 0, 17'd32768, 18'd0), gaps);
        // zero drag stops the particle
        send_item(make_item(Q_ONE, Q_ONE, Q_ONE, 32'h1234_5678, 32'h8765_4321,
                            32'h0F0F_0F0F, 31'd200000, Q_ONE, 17'd0, 18'd65536), gaps);
        // large step of two seconds
        send_item(make_item(0, Q_ONE, 0, Q_ONE, Q_ONE, Q_ONE,
                            31'd10 << 16, Q_ONE, 17'd65536, 18'd131072), gaps);
        // resting on the floor, and starting below it
        send_item(make_item(0, 0, 0, 0, 0, 0, 31'd1000, 0, 17'd65536, 18'd1), gaps);
        send_item(make_item(0, 32'hFFFF_FFFF, 0, Q_ONE, 0, Q_ONE,
                            31'd1000, 0, 17'd65536, 18'd1), gaps);
        // alternating bit patterns on every field
        send_item(make_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                            32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                            31'h5555_5555, 32'hAAAA_AAAA, 17'h15555, 18'h2AAAA), gaps);
        send_item(make_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                            32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                            31'h2AAA_AAAA, 32'h5555_5555, 17'h0AAAA, 18'h15555), gaps);
        // gravity overflows the vertical velocity
        send_item(make_item(0, S_MAX, 0, 0, S_MAX, 0,
                            31'h7FFF_FFFF, S_MAX, 17'd65536, 18'h3FFFF), gaps);

        // random records, with calm stretches and a calm tail
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 150 == 0)
            begin
                calm = ($urandom_range(0, 3) == 0);
            end
            gaps = !calm && (n < RANDOM_ITEMS - CALM_TAIL);
            idle_en <= gaps;
            send_item(random_item(), gaps);
        end
        item_valid <= 1'b0;

        // drain
        while (sb.pending_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3 * PIPE_LATENCY) @(posedge clk);

        if (sb.errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/pis_pkg.sv
hdl/pis_mul.sv
hdl/particle_integration_step.sv
verif/tb_particle_integration_step.sv
